// ===== hw/rtl/tape_language_interpreter_defines.svh =====
// Assertion macros shared by the tape language interpreter RTL.
// No dependencies; each file that asserts includes this header.
`ifndef TAPE_LANGUAGE_INTERPRETER_DEFINES_SVH
`define TAPE_LANGUAGE_INTERPRETER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLI_ASSERT(label, prop, msg)
`define TLI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tli_pkg.sv =====
// Package for the tape language interpreter: sizes, command characters,
// codes and the request, result and queue types. No dependencies.
package tli_pkg;

  localparam int PROGRAM_DEPTH = 1024;
  localparam int TAPE_DEPTH    = 4096;
  localparam int PROG_AW       = $clog2(PROGRAM_DEPTH);
  localparam int LEN_W         = PROG_AW + 1;
  localparam int TAPE_AW       = $clog2(TAPE_DEPTH);
  localparam int PC_W          = 11;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_STEP   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FINISHED  = 3'd1;
  localparam logic [2:0] STAT_OPEN_LEFT = 3'd2;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_LIMIT     = 3'd5;

  typedef enum logic [1:0] {OP_CLEAR, OP_APPEND, OP_STEP, OP_NOP} op_t;

  typedef enum logic [2:0] {
    S_WIPE, S_IDLE, S_EXEC, S_LOAD, S_SCANF, S_SCANB, S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            input_taken;
    logic [PC_W-1:0] program_counter;
    logic [7:0]      cell_value;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== hw/rtl/tli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/tli_front.sv =====
// Front end: accepts requests, classifies the action and queues them.
// Depends on tli_pkg.
module tli_front import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  input  logic        hold,
  output queue_head_t head,
  input  logic        pop
);
  item_t      q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.data = req.data_byte;
    case (req.action)
      ACT_CLEAR:  cls.op = OP_CLEAR;
      ACT_APPEND: cls.op = OP_APPEND;
      ACT_STEP:   cls.op = OP_STEP;
      default:    cls.op = OP_NOP;
    endcase
  end

  // No request is taken while the back end is still clearing the tape.
  assign req_stall = (count == 2'd2) || hold;
  assign push      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rptr];
endmodule

// ===== hw/rtl/tli_back.sv =====
// Back end: program store, tape and the sequencer that carries out queued
// items, with a result register toward the output. Depends on tli_pkg,
// tli_ram and the assertion macro header.
`include "tape_language_interpreter_defines.svh"
module tli_back import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        wiping,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);
  state_t             state, state_next;
  logic [LEN_W-1:0]   length, length_next;
  logic               ended, ended_next;
  logic [LEN_W-1:0]   depth, depth_next;
  logic               underflow, underflow_next;
  logic [LEN_W-1:0]   nc, nc_next;
  logic [TAPE_AW-1:0] tape_pos, tape_pos_next;
  logic [7:0]         cur_cell, cur_cell_next;
  logic [7:0]         data, data_next;
  logic [LEN_W-1:0]   scan_pos, scan_pos_next;
  logic [LEN_W-1:0]   scan_depth, scan_depth_next;
  logic [LEN_W-1:0]   scan_d;
  logic [2:0]         st, st_next;
  logic               ov, ov_next;
  logic [7:0]         ob, ob_next;
  logic               tk, tk_next;
  logic [TAPE_AW-1:0] wipe_addr, wipe_addr_next;
  logic               wipe_last;
  rsp_t               res, res_next;
  logic               res_valid, res_valid_next;

  logic               p_we;
  logic [PROG_AW-1:0] p_raddr;
  logic [7:0]         p_rdata;
  logic               t_we;
  logic [TAPE_AW-1:0] t_waddr, t_raddr;
  logic [7:0]         t_wdata, t_rdata;
  logic [LEN_W-1:0]   nc_inc, nc_dec, sp_inc, sp_dec;
  logic [TAPE_AW-1:0] th_inc, th_dec;

  assign nc_inc = nc + LEN_W'(1);
  assign nc_dec = nc - LEN_W'(1);
  assign sp_inc = scan_pos + LEN_W'(1);
  assign sp_dec = scan_pos - LEN_W'(1);
  assign th_inc = tape_pos + TAPE_AW'(1);
  assign th_dec = tape_pos - TAPE_AW'(1);

  tli_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (p_we),
    .waddr (length[PROG_AW-1:0]),
    .wdata (head.item.data),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  tli_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Bracket depth after the character under the scan; the direction flips
  // which bracket opens a level.
  always_comb begin
    scan_d = scan_depth;
    if (p_rdata == CH_OPEN) begin
      scan_d = (state == S_SCANF) ? scan_depth + LEN_W'(1) : scan_depth - LEN_W'(1);
    end else if (p_rdata == CH_CLOSE) begin
      scan_d = (state == S_SCANF) ? scan_depth - LEN_W'(1) : scan_depth + LEN_W'(1);
    end
  end

  always_comb begin
    state_next      = state;
    length_next     = length;
    ended_next      = ended;
    depth_next      = depth;
    underflow_next  = underflow;
    nc_next         = nc;
    tape_pos_next   = tape_pos;
    cur_cell_next   = cur_cell;
    data_next       = data;
    scan_pos_next   = scan_pos;
    scan_depth_next = scan_depth;
    st_next         = st;
    ov_next         = ov;
    ob_next         = ob;
    tk_next         = tk;
    wipe_addr_next  = wipe_addr;
    res_next        = res;
    res_valid_next  = res_valid && rsp_stall;
    p_we            = 1'b0;
    p_raddr         = nc[PROG_AW-1:0];
    t_we            = 1'b0;
    t_waddr         = tape_pos;
    t_wdata         = 8'h00;
    t_raddr         = tape_pos;
    pop             = 1'b0;
    case (state)
      S_WIPE: begin
        t_we           = 1'b1;
        t_waddr        = wipe_addr;
        wipe_addr_next = wipe_addr + TAPE_AW'(1);
        if (wipe_addr == TAPE_AW'(TAPE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          st_next    = STAT_OK;
          ov_next    = 1'b0;
          ob_next    = 8'h00;
          tk_next    = 1'b0;
          data_next  = head.item.data;
          state_next = S_RESP;
          case (head.item.op)
            OP_CLEAR: begin
              length_next    = '0;
              ended_next     = 1'b0;
              depth_next     = '0;
              underflow_next = 1'b0;
              nc_next        = '0;
            end
            OP_APPEND: begin
              if (!ended) begin
                if (head.item.data == 8'h00) begin
                  ended_next = 1'b1;
                end else if (length == LEN_W'(PROGRAM_DEPTH)) begin
                  st_next = STAT_FULL;
                end else begin
                  p_we        = 1'b1;
                  length_next = length + LEN_W'(1);
                  if (head.item.data == CH_OPEN) begin
                    depth_next = depth + LEN_W'(1);
                  end else if (head.item.data == CH_CLOSE) begin
                    if (depth == '0) begin
                      underflow_next = 1'b1;
                    end else begin
                      depth_next = depth - LEN_W'(1);
                    end
                  end
                end
              end
            end
            OP_STEP: begin
              if (underflow) begin
                st_next = STAT_UNDERFLOW;
              end else if (depth != '0) begin
                st_next = STAT_OPEN_LEFT;
              end else if (nc >= length) begin
                st_next = STAT_FINISHED;
              end else begin
                state_next = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        nc_next    = nc_inc;
        state_next = S_RESP;
        case (p_rdata)
          CH_RIGHT: begin
            if (tape_pos == TAPE_AW'(TAPE_DEPTH - 1)) begin
              st_next = STAT_LIMIT;
            end else begin
              tape_pos_next = th_inc;
              t_raddr       = th_inc;
              state_next    = S_LOAD;
            end
          end
          CH_LEFT: begin
            if (tape_pos != '0) begin
              tape_pos_next = th_dec;
              t_raddr       = th_dec;
              state_next    = S_LOAD;
            end
          end
          CH_PLUS: begin
            t_we          = 1'b1;
            t_wdata       = cur_cell + 8'd1;
            cur_cell_next = cur_cell + 8'd1;
          end
          CH_MINUS: begin
            t_we          = 1'b1;
            t_wdata       = cur_cell - 8'd1;
            cur_cell_next = cur_cell - 8'd1;
          end
          CH_DOT: begin
            ov_next = 1'b1;
            ob_next = cur_cell;
          end
          CH_COMMA: begin
            t_we          = 1'b1;
            t_wdata       = data;
            cur_cell_next = data;
            tk_next       = 1'b1;
          end
          CH_OPEN: begin
            if (cur_cell == 8'h00) begin
              scan_depth_next = LEN_W'(1);
              scan_pos_next   = nc_inc;
              p_raddr         = nc_inc[PROG_AW-1:0];
              state_next      = S_SCANF;
            end
          end
          CH_CLOSE: begin
            if (cur_cell != 8'h00) begin
              if (nc == '0) begin
                nc_next = '0;
              end else begin
                scan_depth_next = LEN_W'(1);
                scan_pos_next   = nc_dec;
                p_raddr         = nc_dec[PROG_AW-1:0];
                state_next      = S_SCANB;
              end
            end
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        cur_cell_next = t_rdata;
        state_next    = S_RESP;
      end
      S_SCANF: begin
        if (scan_pos >= length) begin
          nc_next    = length;
          state_next = S_RESP;
        end else if (scan_d == '0) begin
          nc_next    = sp_inc;
          state_next = S_RESP;
        end else begin
          scan_depth_next = scan_d;
          scan_pos_next   = sp_inc;
          p_raddr         = sp_inc[PROG_AW-1:0];
        end
      end
      S_SCANB: begin
        if (scan_d == '0) begin
          nc_next    = sp_inc;
          state_next = S_RESP;
        end else if (scan_pos == '0) begin
          nc_next    = '0;
          state_next = S_RESP;
        end else begin
          scan_depth_next = scan_d;
          scan_pos_next   = sp_dec;
          p_raddr         = sp_dec[PROG_AW-1:0];
        end
      end
      S_RESP: begin
        if (!res_valid || !rsp_stall) begin
          res_next.status          = st;
          res_next.out_valid       = ov;
          res_next.out_byte        = ob;
          res_next.input_taken     = tk;
          res_next.program_counter = PC_W'(nc);
          res_next.cell_value      = cur_cell;
          res_valid_next           = 1'b1;
          state_next               = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      length    <= '0;
      ended     <= 1'b0;
      depth     <= '0;
      underflow <= 1'b0;
      nc        <= '0;
      tape_pos  <= '0;
      cur_cell  <= 8'h00;
      wipe_addr <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      ended     <= ended_next;
      depth     <= depth_next;
      underflow <= underflow_next;
      nc        <= nc_next;
      tape_pos  <= tape_pos_next;
      cur_cell  <= cur_cell_next;
      wipe_addr <= wipe_addr_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data       <= data_next;
    scan_pos   <= scan_pos_next;
    scan_depth <= scan_depth_next;
    st         <= st_next;
    ov         <= ov_next;
    ob         <= ob_next;
    tk         <= tk_next;
    res        <= res_next;
  end

  assign wiping    = (state == S_WIPE);
  assign wipe_last = wiping && (wipe_addr == TAPE_AW'(TAPE_DEPTH - 1));
  assign rsp_valid = res_valid;
  assign rsp       = res;

  `TLI_ASSERT(a_len_bound, length <= LEN_W'(PROGRAM_DEPTH), "program length past depth")
  `TLI_ASSERT(a_dot_ok, (res_valid && res.out_valid) |-> (res.status == STAT_OK), "bad status")
  `TLI_ASSERT_NEXT(a_wipe_end, wipe_last, state == S_IDLE, "tape clear did not finish")
endmodule

// ===== hw/rtl/tape_language_interpreter.sv =====
// Top level of the tape language interpreter: joins the front end queue
// and the execution back end. Depends on tli_pkg, tli_front and tli_back.
//
// Each request clears the program store, appends one program byte, executes
// one instruction or, for an unused action, does nothing, and yields exactly
// one result. After reset the block clears all TAPE_DEPTH (4096) tape cells
// with req_stall high. A clear, an append, an unused action or a step refused
// for status passes through the accept and result states (S_IDLE, S_RESP);
// an executed command adds S_EXEC, and '<' and '>' that move the head add
// S_LOAD, as the new cell comes from the tape memory's registered read port.
// A bracket jump scans program bytes in S_SCANF or S_SCANB on the program
// store's read port. A two-entry queue behind the front end takes further
// requests while the back end works, and a result register lets the back end
// start the next request while the previous result still waits to be taken.
module tape_language_interpreter import tli_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);
  queue_head_t head;
  logic        pop;
  logic        wiping;

  // The front end classifies each request and buffers it.
  tli_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .hold      (wiping),
    .head      (head),
    .pop       (pop)
  );

  // The back end owns all machine state and drives the result channel.
  tli_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .wiping    (wiping),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );
endmodule
